@@ rtl/core/b64d_pkg.sv @@
// Shared types, codes and character mapping for the base64 stream decoder.
package b64d_pkg;

	// Input commands
	localparam logic CMD_CHAR   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Configuration register indexes
	localparam logic REG_URL_SAFE       = 1'b0;
	localparam logic REG_ALLOW_TRUNCATE = 1'b1;

	// Symbol codes: bit 6 marks an illegal character, bit 7 marks padding
	localparam logic [7:0] SYM_ERR  = 8'd64;
	localparam logic [7:0] SYM_PAD  = 8'd128;
	localparam logic [7:0] SYM_MASK = 8'h3F;

	// Character codes
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_PAD     = 8'h3D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	// Job queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Decoded quad
	typedef struct packed {
		logic            err;
		logic [1:0]      nbytes;
		logic [2:0][7:0] bytes;
	} quad_t;

	// One queued job: up to three bytes, or a single status result
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            err;
		logic            fin;
	} job_t;

	// Map one character through the selected alphabet
	function automatic logic [7:0] map_char(input logic [7:0] c, input logic url);
		logic [7:0] s;
		s = SYM_ERR;
		if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			s = c - CH_UPPER_A;
		end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			s = c - CH_LOWER_A + 8'd26;
		end else if (c inside {[CH_ZERO:CH_NINE]}) begin
			s = c - CH_ZERO + 8'd52;
		end else if (c == CH_PAD) begin
			s = SYM_PAD;
		end else if (url) begin
			if (c == CH_MINUS) s = 8'd62;
			else if (c == CH_UNDER) s = 8'd63;
		end else begin
			if (c == CH_PLUS) s = 8'd62;
			else if (c == CH_SLASH) s = 8'd63;
		end
		return s;
	endfunction

	// Decode four raw characters into bytes or an error
	function automatic quad_t decode_quad(input logic [7:0] q0, input logic [7:0] q1,
			input logic [7:0] q2, input logic [7:0] q3, input logic url);
		logic [7:0] c1, c2, c3, c4, b3, b4;
		quad_t r;
		c1 = map_char(q0, url);
		c2 = map_char(q1, url);
		c3 = map_char(q2, url);
		c4 = map_char(q3, url);
		b3 = c3 & SYM_MASK;
		b4 = c4 & SYM_MASK;
		r.err = ((c1 | c2 | c3 | c4) & SYM_ERR) != 8'd0
			|| ((c1 | c2) & SYM_PAD) != 8'd0
			|| (c3[7] && !c4[7]);
		r.nbytes = 2'd3 - {1'b0, c3[7]} - {1'b0, c4[7]};
		r.bytes[0] = {c1[5:0], c2[5:4]};
		r.bytes[1] = {c2[3:0], b3[5:2]};
		r.bytes[2] = {b3[1:0], b4[5:0]};
		return r;
	endfunction

endpackage

@@ rtl/core/b64d_front.sv @@
// Front end: configuration, character collection and quad decode into jobs.
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic            cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            command,
	input  logic [7:0]      char_code,
	input  logic            fifo_full,
	output logic            push,
	output b64d_pkg::job_t  push_job
);
	import b64d_pkg::*;

	logic       url_safe_q, allow_trunc_q;
	logic [1:0] fill_q, fill_d;
	logic       err_q, err_d;
	logic [7:0] store_q [3];
	logic       wr_store;
	logic       accept;
	logic [7:0] q0, q1, q2, q3;
	quad_t      dec;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_safe_q    <= 1'b0;
			allow_trunc_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_URL_SAFE) url_safe_q <= cfg_data;
			if (cfg_index == REG_ALLOW_TRUNCATE) allow_trunc_q <= cfg_data;
		end
	end

	// Assemble the quad; on finish, pad missing positions with '='
	always_comb begin
		q0 = (command == CMD_CHAR || fill_q > 2'd0) ? store_q[0] : CH_PAD;
		q1 = (command == CMD_CHAR || fill_q > 2'd1) ? store_q[1] : CH_PAD;
		q2 = (command == CMD_CHAR || fill_q > 2'd2) ? store_q[2] : CH_PAD;
		q3 = (command == CMD_CHAR) ? char_code : CH_PAD;
		dec = decode_quad(q0, q1, q2, q3, url_safe_q);
	end

	// Classify the accepted transaction and build its job
	always_comb begin
		push     = 1'b0;
		push_job = '0;
		fill_d   = fill_q;
		err_d    = err_q;
		wr_store = 1'b0;
		if (accept) begin
			if (command == CMD_CHAR) begin
				if (!err_q) begin
					if (fill_q != 2'd3) begin
						wr_store = 1'b1;
						fill_d   = fill_q + 2'd1;
					end else begin
						push            = 1'b1;
						push_job.bytes  = dec.bytes;
						push_job.nbytes = dec.err ? 2'd0 : dec.nbytes;
						push_job.err    = dec.err;
						fill_d          = 2'd0;
						err_d           = dec.err;
					end
				end
			end else begin
				push         = 1'b1;
				push_job.fin = 1'b1;
				fill_d       = 2'd0;
				err_d        = 1'b0;
				if (err_q || (fill_q != 2'd0 && !allow_trunc_q)) begin
					push_job.err = 1'b1;
				end else if (fill_q != 2'd0) begin
					push_job.bytes  = dec.bytes;
					push_job.nbytes = dec.err ? 2'd0 : dec.nbytes;
					push_job.err    = dec.err;
				end
			end
		end
	end

	// Hold fill count and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			err_q  <= 1'b0;
		end else begin
			fill_q <= fill_d;
			err_q  <= err_d;
		end
	end

	// Store raw characters of the partial quad
	always_ff @(posedge clk) begin
		if (wr_store) store_q[fill_q] <= char_code;
	end

endmodule

@@ rtl/core/b64d_fifo.sv @@
// Short job queue between the front end and the result sequencer.
module b64d_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64d_pkg::job_t  push_job,
	input  logic            pop,
	output b64d_pkg::job_t  head,
	output logic            empty,
	output logic            full
);
	import b64d_pkg::*;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == CNT_W'(0));
	assign full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	// Write job entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ rtl/core/b64d_back.sv @@
// Back end: walks each job and issues its results through an output register.
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b64d_pkg::job_t  head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            syntax_error,
	output logic            stream_end,
	output logic            last_in_run
);
	import b64d_pkg::*;

	logic [1:0] k_q;
	logic [1:0] nres;
	logic       last;
	logic       load;
	logic       ov_q;

	// Result count and last-result detect for the head job
	assign nres = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
	assign last = (k_q == nres - 2'd1);
	assign load = !empty && (!ov_q || out_ready);
	assign pop  = load && last;

	assign out_valid = ov_q;

	// Track position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			if (load) k_q <= last ? 2'd0 : k_q + 2'd1;
			if (load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			data_byte    <= (head.nbytes != 2'd0) ? head.bytes[k_q] : 8'd0;
			byte_valid   <= (head.nbytes != 2'd0);
			syntax_error <= head.err;
			stream_end   <= head.fin && last;
			last_in_run  <= last;
		end
	end

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Base64 stream decoder top level.
// Usage:
//   Write url_safe (index 0) and allow_truncate (index 1) through cfg_we,
//   cfg_index and cfg_data while the decoder is idle.
//   Send one transaction per character on the input channel with command 0,
//   and a transaction with command 1 to finish the stream.
//   Each fourth character (with no error held) and each finish yield one to
//   three results on the output channel: decoded bytes, or a status result.
// Timing:
//   One input transaction per cycle is taken while the job queue has room.
//   The first result of a transaction passes through the job queue and the output
//   register; a job's results then leave one per cycle while the receiver is
//   ready, set by the result sequencer.
//   Four characters give at most three results, so the stream sustains one
//   character per cycle while the receiver is ready.
// Reset clears the configuration, the partial quad count, the sticky error,
//   the job queue and the output valid flag.
// When the receiver stalls, the output register holds its result, the queue
//   of four jobs fills, and then in_ready drops.
module base64_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       syntax_error,
	output logic       stream_end,
	output logic       last_in_run
);
	import b64d_pkg::*;

	logic push, pop, empty, full;
	job_t push_job, head;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.char_code (char_code),
		.fifo_full (full),
		.push      (push),
		.push_job  (push_job)
	);

	b64d_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.syntax_error (syntax_error),
		.stream_end   (stream_end),
		.last_in_run  (last_in_run)
	);

endmodule

@@ rtl/core/b64d_checker.sv @@
// Port-level checks for the base64 stream decoder, bound to the top level.
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte,
	input logic       byte_valid,
	input logic       syntax_error,
	input logic       stream_end,
	input logic       last_in_run
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// An error result carries no byte
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && syntax_error |-> !byte_valid && data_byte == 8'd0)
		else $error("error result carries data");

	// Stream end closes its transaction
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> last_in_run)
		else $error("stream end not on last result");

	// A status result has zero data and ends its transaction
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> data_byte == 8'd0 && last_in_run)
		else $error("status result malformed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
